// ===== rtl/fkdc_pkg.sv =====
// fkdc_pkg: shared widths, register indexes and item types for the
// five-key debouncer with ok+up combo detection. No dependencies.
package fkdc_pkg;

   // key count and key positions in the level vectors
   localparam int NUM_KEYS = 5;
   localparam int KEY_UP   = 0;
   localparam int KEY_OK   = NUM_KEYS - 1;

   // field widths
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 8;
   localparam int COMBO_W     = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // register reset values
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(30);
   localparam logic [COMBO_W-1:0]    COMBO_RESET    = COMBO_W'(5000);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TIME = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TIME   = CSR_INDEX_W'(1);

   // one poll
   typedef struct packed {
      logic [TIME_W-1:0]   now_ms;
      logic [NUM_KEYS-1:0] key_pressed;
      logic [NUM_KEYS:0]   ack_mask;
   } req_type;

   // one report
   typedef struct packed {
      logic [NUM_KEYS-1:0] press_flags;
      logic                combo_flag;
      logic [NUM_KEYS-1:0] stable_keys;
   } rsp_type;

endpackage

// ===== rtl/five_key_debounce_combo.sv =====
// five_key_debounce_combo: time-based key debouncer with press latches and
// an ok+up long-hold combo latch. Depends on fkdc_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  req     | in        | req_valid/req_ready  | fkdc_pkg::req_type (poll)
//  rsp     | out       | rsp_valid/rsp_ready  | fkdc_pkg::rsp_type (report)
//  csr     | in        | csr_wr_en, no wait   | csr_index, csr_data
//
// One poll per cycle sustained while reports are taken; a poll passes the
// input register, then the key/combo update into the result register, and
// its report is valid once it sits in the result register.
// Synchronous reset releases all keys and loads debounce 30, combo 5000.
// A stalled report holds the result register; the input register still
// takes one more poll and the ready chain backs up from there.
module five_key_debounce_combo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  fkdc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fkdc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [fkdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fkdc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int NK = fkdc_pkg::NUM_KEYS;
   localparam int TW = fkdc_pkg::TIME_W;

   // configuration registers
   logic [fkdc_pkg::DEBOUNCE_W-1:0] settle_time_ff;
   logic [fkdc_pkg::COMBO_W-1:0]    hold_time_ff;

   // pipeline registers
   logic              in_valid_ff;
   fkdc_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   fkdc_pkg::rsp_type out_data_ff;

   // key and combo state
   logic [NK-1:0] raw_level_ff,   raw_level_in;
   logic [NK-1:0] stable_level_ff, stable_level_in;
   logic [NK-1:0] press_latch_ff, press_latch_in;
   logic [TW-1:0] change_time_ff [NK];
   logic [TW-1:0] change_time_in [NK];
   logic          combo_running_ff, combo_running_in;
   logic [TW-1:0] combo_start_ff,   combo_start_in;
   logic          combo_latch_ff,   combo_latch_in;
   fkdc_pkg::rsp_type report_in;

   logic advance;
   logic out_free;

   // handshake
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_time_ff <= fkdc_pkg::DEBOUNCE_RESET;
         hold_time_ff   <= fkdc_pkg::COMBO_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            fkdc_pkg::CSR_SETTLE_TIME: begin
               settle_time_ff <= csr_data[fkdc_pkg::DEBOUNCE_W-1:0];
            end
            fkdc_pkg::CSR_HOLD_TIME: begin
               hold_time_ff <= csr_data[fkdc_pkg::COMBO_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // per-key debounce, combo timer, report and acknowledge
   always_comb begin
      logic [TW-1:0] elapsed;
      logic [TW-1:0] start_eff;
      logic          both;
      logic [NK-1:0] latch_rep;
      logic          combo_rep;
      raw_level_in    = raw_level_ff;
      stable_level_in = stable_level_ff;
      latch_rep       = press_latch_ff;
      for (int k = 0; k < NK; k++) begin
         change_time_in[k] = change_time_ff[k];
         if (in_data_ff.key_pressed[k] != raw_level_ff[k]) begin
            change_time_in[k] = in_data_ff.now_ms;
         end
         raw_level_in[k] = in_data_ff.key_pressed[k];
         elapsed = in_data_ff.now_ms - change_time_in[k];
         if (elapsed >= {{(TW-fkdc_pkg::DEBOUNCE_W){1'b0}}, settle_time_ff} &&
             stable_level_ff[k] != raw_level_in[k]) begin
            stable_level_in[k] = raw_level_in[k];
            if (raw_level_in[k]) begin
               latch_rep[k] = 1'b1;
            end
         end
      end

      // combo timer on the updated stable levels
      both      = stable_level_in[fkdc_pkg::KEY_OK] && stable_level_in[fkdc_pkg::KEY_UP];
      start_eff = combo_running_ff ? combo_start_ff : in_data_ff.now_ms;
      elapsed   = in_data_ff.now_ms - start_eff;
      combo_rep = combo_latch_ff;
      if (both) begin
         combo_running_in = 1'b1;
         combo_start_in   = start_eff;
         if (elapsed >= {{(TW-fkdc_pkg::COMBO_W){1'b0}}, hold_time_ff}) begin
            combo_rep = 1'b1;
         end
      end else begin
         combo_running_in = 1'b0;
         combo_start_in   = '0;
      end

      // report shows latches before the acknowledge clear
      report_in.press_flags = latch_rep;
      report_in.combo_flag  = combo_rep;
      report_in.stable_keys = stable_level_in;
      press_latch_in = latch_rep & ~in_data_ff.ack_mask[NK-1:0];
      combo_latch_in = combo_rep & ~in_data_ff.ack_mask[NK];
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_data_ff <= report_in;
      end
   end

   // state update when an item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_level_ff     <= '0;
         stable_level_ff  <= '0;
         press_latch_ff   <= '0;
         combo_running_ff <= 1'b0;
         combo_start_ff   <= '0;
         combo_latch_ff   <= 1'b0;
         for (int k = 0; k < NK; k++) begin
            change_time_ff[k] <= '0;
         end
      end else if (advance) begin
         raw_level_ff     <= raw_level_in;
         stable_level_ff  <= stable_level_in;
         press_latch_ff   <= press_latch_in;
         combo_running_ff <= combo_running_in;
         combo_start_ff   <= combo_start_in;
         combo_latch_ff   <= combo_latch_in;
         for (int k = 0; k < NK; k++) begin
            change_time_ff[k] <= change_time_in[k];
         end
      end
   end

endmodule
